// ===== src/lfps_pkg.sv =====
// Shared types, widths and constants for the line follower steering block.
// No dependencies; every other file imports this package.
package lfps_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int SAMPLE_W     = 10;
  localparam int WEIGHT_W     = 5;
  localparam int NUM_W        = 6;
  localparam int MAG_W        = 5;
  localparam int DEN_W        = $clog2(SENSOR_COUNT + 1);
  localparam int Q_SHIFT      = 8;
  localparam int DIV_RADIX_W  = 4;
  localparam int DIVD_W       = 16;
  localparam int DIV_CNT_W    = 2;
  localparam int ERR_W        = 12;
  localparam int DIFF_W       = ERR_W + 1;
  localparam int SUM_W        = 24;
  localparam int GAIN_W       = 12;
  localparam int SPEED_W      = 11;
  localparam int OUT_W        = 12;
  localparam int PP_W         = GAIN_W + 1 + ERR_W;
  localparam int PI_W         = GAIN_W + 1 + SUM_W;
  localparam int PD_W         = GAIN_W + 1 + DIFF_W;
  localparam int TOT_W        = PI_W + 1;
  localparam int CORR_W       = TOT_W - Q_SHIFT;
  localparam int CL_W         = CORR_W + 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 12;

  typedef logic signed [WEIGHT_W-1:0] weight_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_THRESHOLD = 3'd0,
    REG_NOMINAL_SPEED  = 3'd1,
    REG_SPEED_LIMIT    = 3'd2,
    REG_GAIN_P         = 3'd3,
    REG_GAIN_I         = 3'd4,
    REG_GAIN_D         = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             seen;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [DEN_W-1:0] den;
  } merge_t;

  typedef struct packed {
    logic eval;
    logic mul;
    logic add;
  } pid_ctrl_t;

  function automatic weight_t lane_weight(input int idx);
    return WEIGHT_W'(2 * idx - (SENSOR_COUNT - 1));
  endfunction

endpackage

// ===== src/lfps_lane.sv =====
// One sensor lane: threshold compare and weight contribution.
// Depends on lfps_pkg.
module lfps_lane import lfps_pkg::*; (
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SAMPLE_W-1:0] threshold,
  input  weight_t             weight,
  output logic                mark,
  output weight_t             contrib
);

  assign mark    = sample > threshold;
  assign contrib = mark ? weight : '0;

endmodule

// ===== src/lfps_merge.sv =====
// Merging stage: sums the lane weights and counts the marked sensors.
// Depends on lfps_pkg.
module lfps_merge import lfps_pkg::*; (
  input  logic    mark    [SENSOR_COUNT],
  input  weight_t contrib [SENSOR_COUNT],
  output merge_t  result
);

  logic signed [NUM_W-1:0] num;
  logic        [DEN_W-1:0] den;
  logic signed [NUM_W-1:0] num_neg;

  always_comb begin
    num = '0;
    den = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      num = num + NUM_W'(contrib[i]);
      den = den + DEN_W'(mark[i]);
    end
  end

  assign num_neg = -num;

  assign result.seen = den != '0;
  assign result.neg  = num[NUM_W-1];
  assign result.mag  = num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
  assign result.den  = den;

endmodule

// ===== src/lfps_div.sv =====
// Radix-16 restoring divider: (mag << 8) / den, four quotient bits a cycle.
// Depends on lfps_pkg.
module lfps_div import lfps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  mag,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [DIVD_W-1:0] quot
);

  logic                   active;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [DIVD_W-1:0]      dividend;
  logic [DEN_W:0]         rem;
  logic [DEN_W-1:0]       divisor;
  logic [DIVD_W-1:0]      dividend_next;
  logic [DEN_W:0]         rem_next;
  logic [DIVD_W-1:0]      quot_next;

  always_comb begin
    logic [DEN_W:0] trial;
    dividend_next = dividend;
    rem_next      = rem;
    quot_next     = quot;
    for (int k = 0; k < DIV_RADIX_W; k++) begin
      trial         = {rem_next[DEN_W-1:0], dividend_next[DIVD_W-1]};
      dividend_next = {dividend_next[DIVD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next  = trial - {1'b0, divisor};
        quot_next = {quot_next[DIVD_W-2:0], 1'b1};
      end else begin
        rem_next  = trial;
        quot_next = {quot_next[DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == '1);
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {{(DIVD_W - MAG_W - Q_SHIFT){1'b0}}, mag, {Q_SHIFT{1'b0}}};
      rem      <= '0;
      quot     <= '0;
      divisor  <= den;
    end else if (active) begin
      dividend <= dividend_next;
      rem      <= rem_next;
      quot     <= quot_next;
    end
  end

endmodule

// ===== src/lfps_pid.sv =====
// PID datapath: error selection, saturating integral, products, sum and clamp.
// Depends on lfps_pkg; holds the previous error and the error sum.
module lfps_pid import lfps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  pid_ctrl_t               ctrl,
  input  logic [DIVD_W-1:0]       quot,
  input  logic                    neg,
  input  logic                    seen,
  input  logic [GAIN_W-1:0]       gain_p,
  input  logic [GAIN_W-1:0]       gain_i,
  input  logic [GAIN_W-1:0]       gain_d,
  input  logic [SPEED_W-1:0]      nominal_speed,
  input  logic [SPEED_W-1:0]      speed_limit,
  output logic signed [OUT_W-1:0] left_w,
  output logic signed [OUT_W-1:0] right_w,
  output logic signed [ERR_W-1:0] err
);

  localparam logic signed [SUM_W:0] SumMax = (SUM_W + 1)'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W:0] SumMin = -(SUM_W + 1)'(1 << (SUM_W - 1));

  logic signed [ERR_W-1:0]  previous_error;
  logic signed [SUM_W-1:0]  error_sum;
  logic signed [ERR_W-1:0]  e_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [DIFF_W-1:0] d_q;
  logic signed [PP_W-1:0]   p_prod;
  logic signed [PI_W-1:0]   i_prod;
  logic signed [PD_W-1:0]   d_prod;
  logic signed [CORR_W-1:0] corr;

  logic signed [ERR_W-1:0]  e_mag;
  logic signed [ERR_W-1:0]  e_next;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [DIFF_W-1:0] d_next;
  logic signed [TOT_W-1:0]  total;
  logic signed [CL_W-1:0]   base_s;
  logic signed [CL_W-1:0]   max_s;
  logic signed [CL_W-1:0]   left_raw;
  logic signed [CL_W-1:0]   right_raw;
  logic signed [CL_W-1:0]   left_cl;
  logic signed [CL_W-1:0]   right_cl;

  assign e_mag  = signed'(quot[ERR_W-1:0]);
  assign e_next = seen ? (neg ? -e_mag : e_mag) : previous_error;

  assign sum_wide = (SUM_W + 1)'(error_sum) + (SUM_W + 1)'(e_next);

  always_comb begin
    if (sum_wide > SumMax) begin
      sum_next = SumMax[SUM_W-1:0];
    end else if (sum_wide < SumMin) begin
      sum_next = SumMin[SUM_W-1:0];
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  assign d_next = DIFF_W'(e_next) - DIFF_W'(previous_error);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_sum      <= '0;
    end else if (ctrl.eval) begin
      previous_error <= e_next;
      error_sum      <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.eval) begin
      e_q   <= e_next;
      sum_q <= sum_next;
      d_q   <= d_next;
    end
    if (ctrl.mul) begin
      p_prod <= PP_W'(signed'({1'b0, gain_p})) * PP_W'(e_q);
      i_prod <= PI_W'(signed'({1'b0, gain_i})) * PI_W'(sum_q);
      d_prod <= PD_W'(signed'({1'b0, gain_d})) * PD_W'(d_q);
    end
    if (ctrl.add) begin
      corr <= total[TOT_W-1:Q_SHIFT];
    end
  end

  assign total = TOT_W'(p_prod) + TOT_W'(i_prod) + TOT_W'(d_prod);

  assign base_s    = CL_W'(signed'({1'b0, nominal_speed}));
  assign max_s     = CL_W'(signed'({1'b0, speed_limit}));
  assign left_raw  = base_s + CL_W'(corr);
  assign right_raw = base_s - CL_W'(corr);

  always_comb begin
    if (left_raw > max_s) begin
      left_cl = max_s;
    end else if (left_raw < -max_s) begin
      left_cl = -max_s;
    end else begin
      left_cl = left_raw;
    end
    if (right_raw > max_s) begin
      right_cl = max_s;
    end else if (right_raw < -max_s) begin
      right_cl = -max_s;
    end else begin
      right_cl = right_raw;
    end
  end

  assign left_w  = left_cl[OUT_W-1:0];
  assign right_w = right_cl[OUT_W-1:0];
  assign err     = e_q;

endmodule

// ===== src/line_follow_pid_steer.sv =====
// Eight-sensor PID line follower steering block, top level.
// Depends on lfps_pkg, lfps_lane, lfps_merge, lfps_div and lfps_pid.
//
// One request carries eight reflectance samples; each is compared with the line
// threshold in a lane of its own, and a merging stage forms the weighted sum and
// count of the marked sensors. The centroid in Q8 is divided out by a radix-16
// divider, then the PID terms take three more stages. A request occupies the
// block from acceptance until its result is loaded into an output register, and
// that register holds it so that the next request may be accepted while the
// result still waits to be taken.
module line_follow_pid_steer import lfps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_W-1:0]     sensor_0,
  input  logic [SAMPLE_W-1:0]     sensor_1,
  input  logic [SAMPLE_W-1:0]     sensor_2,
  input  logic [SAMPLE_W-1:0]     sensor_3,
  input  logic [SAMPLE_W-1:0]     sensor_4,
  input  logic [SAMPLE_W-1:0]     sensor_5,
  input  logic [SAMPLE_W-1:0]     sensor_6,
  input  logic [SAMPLE_W-1:0]     sensor_7,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] left_cmd,
  output logic signed [OUT_W-1:0] right_cmd,
  output logic signed [ERR_W-1:0] position_error,
  output logic                    line_seen,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  state_t state;
  state_t state_next;

  logic [SAMPLE_W-1:0] line_threshold;
  logic [SPEED_W-1:0]  nominal_speed;
  logic [SPEED_W-1:0]  speed_limit;
  logic [GAIN_W-1:0]   gain_p;
  logic [GAIN_W-1:0]   gain_i;
  logic [GAIN_W-1:0]   gain_d;

  logic [SAMPLE_W-1:0] sample  [8];
  logic                mark    [SENSOR_COUNT];
  weight_t             contrib [SENSOR_COUNT];
  merge_t              merged;

  logic                seen_q;
  logic                neg_q;
  logic                div_start;
  logic                div_done;
  logic [DIVD_W-1:0]   quot;
  pid_ctrl_t           ctrl;
  logic                out_load;

  logic signed [OUT_W-1:0] left_w;
  logic signed [OUT_W-1:0] right_w;
  logic signed [ERR_W-1:0] err_w;

  assign sample[0] = sensor_0;
  assign sample[1] = sensor_1;
  assign sample[2] = sensor_2;
  assign sample[3] = sensor_3;
  assign sample[4] = sensor_4;
  assign sample[5] = sensor_5;
  assign sample[6] = sensor_6;
  assign sample[7] = sensor_7;

  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
    lfps_lane u_lane (
      .sample    (sample[i]),
      .threshold (line_threshold),
      .weight    (lane_weight(i)),
      .mark      (mark[i]),
      .contrib   (contrib[i])
    );
  end

  lfps_merge u_merge (
    .mark    (mark),
    .contrib (contrib),
    .result  (merged)
  );

  lfps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (merged.mag),
    .den   (merged.den),
    .done  (div_done),
    .quot  (quot)
  );

  lfps_pid u_pid (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .quot          (quot),
    .neg           (neg_q),
    .seen          (seen_q),
    .gain_p        (gain_p),
    .gain_i        (gain_i),
    .gain_d        (gain_d),
    .nominal_speed (nominal_speed),
    .speed_limit   (speed_limit),
    .left_w        (left_w),
    .right_w       (right_w),
    .err           (err_w)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == ST_IDLE;
    div_start = in_valid && (state == ST_IDLE);
    ctrl.eval = state == ST_EVAL;
    ctrl.mul  = state == ST_MUL;
    ctrl.add  = state == ST_ADD;
    out_load  = (state == ST_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      seen_q <= merged.seen;
      neg_q  <= merged.neg;
    end
    if (out_load) begin
      left_cmd       <= left_w;
      right_cmd      <= right_w;
      position_error <= err_w;
      line_seen      <= seen_q;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_threshold <= SAMPLE_W'(200);
      nominal_speed  <= SPEED_W'(717);
      speed_limit    <= SPEED_W'(840);
      gain_p         <= GAIN_W'(205);
      gain_i         <= '0;
      gain_d         <= GAIN_W'(512);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LINE_THRESHOLD: line_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_NOMINAL_SPEED:  nominal_speed  <= cfg_data[SPEED_W-1:0];
        REG_SPEED_LIMIT:    speed_limit    <= cfg_data[SPEED_W-1:0];
        REG_GAIN_P:         gain_p         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:         gain_i         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:         gain_d         <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the eight-sensor PID line follower steering block.
// Depends on lfps_pkg and line_follow_pid_steer; a scoreboard class predicts each
// steering result from the samples and register settings and checks it in order.
module tb;
  import lfps_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int ERR_SUM_MAX  = (1 << (SUM_W - 1)) - 1;
  localparam int ERR_SUM_MIN  = -(1 << (SUM_W - 1));
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] samples_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_cmd;
    logic signed [OUT_W-1:0] right_cmd;
    logic signed [ERR_W-1:0] position_error;
    logic                    line_seen;
  } steer_cmd_t;

  typedef enum {TAKE_ALWAYS, TAKE_OFTEN, TAKE_PERIODIC, TAKE_RARELY} take_pattern_t;
  typedef enum {TRACK_MIXED, TRACK_RIGHT_RIM, TRACK_LEFT_RIM} track_t;

  class steer_scoreboard;
    logic [SAMPLE_W-1:0] line_thr;
    logic [SPEED_W-1:0]  base_spd;
    logic [SPEED_W-1:0]  max_spd;
    logic [GAIN_W-1:0]   kp;
    logic [GAIN_W-1:0]   ki;
    logic [GAIN_W-1:0]   kd;
    int                  last_err;
    longint              err_integral;
    steer_cmd_t          steering_due[$];
    int                  errors;

    function new();
      line_thr     = 200;
      base_spd     = 717;
      max_spd      = 840;
      kp           = 205;
      ki           = 0;
      kd           = 512;
      last_err     = 0;
      err_integral = 0;
      errors       = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LINE_THRESHOLD: line_thr = data[SAMPLE_W-1:0];
        REG_NOMINAL_SPEED:  base_spd = data[SPEED_W-1:0];
        REG_SPEED_LIMIT:    max_spd  = data[SPEED_W-1:0];
        REG_GAIN_P:         kp       = data[GAIN_W-1:0];
        REG_GAIN_I:         ki       = data[GAIN_W-1:0];
        REG_GAIN_D:         kd       = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_speed(longint v);
      if (v > longint'(max_spd)) return longint'(max_spd);
      if (v < -longint'(max_spd)) return -longint'(max_spd);
      return v;
    endfunction

    function void note_request(samples_t s);
      int         weight_sum;
      int         marked;
      int         e;
      longint     deriv;
      longint     corr;
      steer_cmd_t want;
      weight_sum = 0;
      marked     = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (s[i] > line_thr) begin
          weight_sum += 2 * i - (SENSOR_COUNT - 1);
          marked++;
        end
      end
      e = (marked != 0) ? (weight_sum * (1 << Q_SHIFT)) / marked : last_err;
      err_integral = err_integral + e;
      if (err_integral > ERR_SUM_MAX) err_integral = ERR_SUM_MAX;
      if (err_integral < ERR_SUM_MIN) err_integral = ERR_SUM_MIN;
      deriv = longint'(e) - last_err;
      corr = (longint'(kp) * e + longint'(ki) * err_integral + longint'(kd) * deriv)
             >>> Q_SHIFT;
      last_err = e;
      want.left_cmd       = OUT_W'(clamp_speed(longint'(base_spd) + corr));
      want.right_cmd      = OUT_W'(clamp_speed(longint'(base_spd) - corr));
      want.position_error = ERR_W'(e);
      want.line_seen      = (marked != 0);
      steering_due.push_back(want);
    endfunction

    function void check_result(steer_cmd_t got);
      steer_cmd_t want;
      if (steering_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: result with nothing outstanding: left %0d right %0d err %0d seen %0d",
                   got.left_cmd, got.right_cmd, got.position_error, got.line_seen);
        return;
      end
      want = steering_due.pop_front();
      if (want !== got) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: mismatch: expected left %0d right %0d err %0d seen %0d",
                   want.left_cmd, want.right_cmd, want.position_error, want.line_seen);
          $display("tb:           got      left %0d right %0d err %0d seen %0d",
                   got.left_cmd, got.right_cmd, got.position_error, got.line_seen);
        end
      end
    endfunction
  endclass

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    out_ready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  samples_t                sample_bus = '0;
  logic                    in_ready;
  logic                    out_valid;
  logic                    cfg_ready;
  logic signed [OUT_W-1:0] left_cmd;
  logic signed [OUT_W-1:0] right_cmd;
  logic signed [ERR_W-1:0] position_error;
  logic                    line_seen;

  take_pattern_t   take_pattern = TAKE_ALWAYS;
  int unsigned     stall_tick   = 0;
  int unsigned     cycles       = 0;
  steer_scoreboard sb           = new();

  line_follow_pid_steer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sensor_0       (sample_bus[0]),
    .sensor_1       (sample_bus[1]),
    .sensor_2       (sample_bus[2]),
    .sensor_3       (sample_bus[3]),
    .sensor_4       (sample_bus[4]),
    .sensor_5       (sample_bus[5]),
    .sensor_6       (sample_bus[6]),
    .sensor_7       (sample_bus[7]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_cmd       (left_cmd),
    .right_cmd      (right_cmd),
    .position_error (position_error),
    .line_seen      (line_seen),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (take_pattern)
      TAKE_ALWAYS:   out_ready <= 1'b1;
      TAKE_OFTEN:    out_ready <= ($urandom_range(0, 3) != 0);
      TAKE_PERIODIC: out_ready <= ((stall_tick % 7) >= 3);
      default:       out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({left_cmd, right_cmd, position_error, line_seen});
  end

  function automatic int above_thr(int thr);
    return (thr >= SAMPLE_MAX) ? SAMPLE_MAX : $urandom_range(thr + 1, SAMPLE_MAX);
  endfunction

  function automatic int below_thr(int thr);
    return $urandom_range(0, thr);
  endfunction

  function automatic samples_t lit_lanes(logic [SENSOR_COUNT-1:0] mask, int on_val, int off_val);
    samples_t s;
    for (int i = 0; i < SENSOR_COUNT; i++)
      s[i] = mask[i] ? SAMPLE_W'(on_val) : SAMPLE_W'(off_val);
    return s;
  endfunction

  function automatic samples_t line_samples(int thr);
    samples_t                s;
    logic [SENSOR_COUNT-1:0] marks;
    int                      lo;
    int                      w;
    int                      v;
    lo    = $urandom_range(0, SENSOR_COUNT - 1);
    w     = $urandom_range(1, 3);
    marks = '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        for (int i = lo; i < lo + w && i < SENSOR_COUNT; i++) marks[i] = 1'b1;
      end
      6: marks = '0;
      7: marks = SENSOR_COUNT'($urandom);
      8: begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          v = thr + $urandom_range(0, 2) - 1;
          if (v < 0) v = 0;
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
          s[i] = SAMPLE_W'(v);
        end
        return s;
      end
      default: begin
        for (int i = 0; i < SENSOR_COUNT; i++)
          s[i] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        return s;
      end
    endcase
    for (int i = 0; i < SENSOR_COUNT; i++)
      s[i] = SAMPLE_W'(marks[i] ? above_thr(thr) : below_thr(thr));
    return s;
  endfunction

  function automatic samples_t rim_samples(int lane, int thr);
    samples_t s;
    for (int i = 0; i < SENSOR_COUNT; i++) s[i] = SAMPLE_W'(below_thr(thr));
    if ($urandom_range(0, 4) != 0) s[lane] = SAMPLE_W'(above_thr(thr));
    return s;
  endfunction

  function automatic int field_value(int width);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return (1 << width) - 1;
      default: return $urandom_range(0, (1 << width) - 1);
    endcase
  endfunction

  task automatic send_tick(samples_t s);
    in_valid   <= 1'b1;
    sample_bus <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(sample_bus);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(cfg_index, cfg_data);
  endtask

  // Spare bits above the threshold and speed field widths are filled at random; the block must drop them.
  task automatic program_regs(int thr, int base, int vmax, int gp, int gi, int gd);
    write_reg(REG_LINE_THRESHOLD, CFG_DATA_W'(thr) | (CFG_DATA_W'($urandom) << SAMPLE_W));
    write_reg(REG_NOMINAL_SPEED, CFG_DATA_W'(base) | (CFG_DATA_W'($urandom) << SPEED_W));
    write_reg(REG_SPEED_LIMIT, CFG_DATA_W'(vmax) | (CFG_DATA_W'($urandom) << SPEED_W));
    write_reg(REG_GAIN_P, CFG_DATA_W'(gp));
    write_reg(REG_GAIN_I, CFG_DATA_W'(gi));
    write_reg(REG_GAIN_D, CFG_DATA_W'(gd));
    write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_regs();
    program_regs(field_value(SAMPLE_W), field_value(SPEED_W), field_value(SPEED_W),
                 field_value(GAIN_W), field_value(GAIN_W), field_value(GAIN_W));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.steering_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_ticks(int count, track_t track, int max_gap);
    int remaining;
    int burst;
    int gap;
    remaining = count;
    while (remaining > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > remaining) burst = remaining;
      repeat (burst) begin
        case (track)
          TRACK_RIGHT_RIM: send_tick(rim_samples(SENSOR_COUNT - 1, sb.line_thr));
          TRACK_LEFT_RIM:  send_tick(rim_samples(0, sb.line_thr));
          default:         send_tick(line_samples(sb.line_thr));
        endcase
      end
      remaining -= burst;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    int phase;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Register values from reset: no line, full line, the outermost sensors, held
    // error, samples at and just above the threshold, and centroids that truncate.
    send_tick(lit_lanes(8'h00, SAMPLE_MAX, 0));
    send_tick(lit_lanes(8'hFF, SAMPLE_MAX, 0));
    send_tick(lit_lanes(8'b0000_0001, SAMPLE_MAX, 0));
    send_tick(lit_lanes(8'h00, SAMPLE_MAX, 0));
    send_tick(lit_lanes(8'b1000_0000, SAMPLE_MAX, 0));
    send_tick(lit_lanes(8'hFF, 200, 0));
    send_tick(lit_lanes(8'hFF, 201, 0));
    send_tick(lit_lanes(8'b0000_1011, 201, 200));
    send_tick(lit_lanes(8'b1101_0000, SAMPLE_MAX, 0));
    send_tick(lit_lanes(8'b0000_0011, SAMPLE_MAX, 0));
    send_tick(lit_lanes(8'b0001_1000, SAMPLE_MAX, 0));
    send_tick(lit_lanes(8'b0111_1101, SAMPLE_MAX, 0));
    send_tick(lit_lanes(8'b1010_1010, SAMPLE_MAX, 0));
    wait_idle();

    program_regs(0, 0, (1 << SPEED_W) - 1, (1 << GAIN_W) - 1, (1 << GAIN_W) - 1,
                 (1 << GAIN_W) - 1);
    send_tick(lit_lanes(8'h00, SAMPLE_MAX, 0));
    send_tick(lit_lanes(8'hFF, 1, 0));
    send_tick(lit_lanes(8'b0000_0001, 1, 0));
    send_tick(lit_lanes(8'b1000_0000, SAMPLE_MAX, 0));
    wait_idle();

    program_regs(SAMPLE_MAX, (1 << SPEED_W) - 1, 0, 0, 0, 0);
    send_tick(lit_lanes(8'hFF, SAMPLE_MAX, 0));
    send_tick(line_samples(SAMPLE_MAX));
    wait_idle();

    // Clamp below the nominal speed.
    program_regs(512, 1500, 300, (1 << GAIN_W) - 1, 0, 0);
    send_tick(lit_lanes(8'hF0, 513, 512));
    send_tick(lit_lanes(8'h0F, 513, 512));
    send_tick(lit_lanes(8'h00, 513, 512));
    wait_idle();

    for (phase = 0; phase < 8; phase++) begin
      take_pattern = take_pattern_t'(phase % 4);
      random_regs();
      run_ticks(170, TRACK_MIXED, (phase % 3) * 4);
      wait_idle();
    end

    // Drive the integral far to one side and back; a small integral gain keeps
    // the point where the correction changes sign visible at the wheels.
    take_pattern = TAKE_ALWAYS;
    program_regs(512, 1024, (1 << SPEED_W) - 1, $urandom_range(0, 300), 1,
                 $urandom_range(0, 300));
    run_ticks(120, TRACK_RIGHT_RIM, 0);
    run_ticks(120, TRACK_LEFT_RIM, 0);
    wait_idle();

    take_pattern = TAKE_OFTEN;
    random_regs();
    run_ticks(80, TRACK_MIXED, 3);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.steering_due.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/lfps_pkg.sv
src/lfps_lane.sv
src/lfps_merge.sv
src/lfps_div.sv
src/lfps_pid.sv
src/line_follow_pid_steer.sv
tb/tb.sv
